@@ design/spq_pkg.sv @@
// Package: shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int DATA_W = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                     valid;
		logic                     le;
		logic signed [DATA_W-1:0] data;
	} link_t;

endpackage
`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Top level: sorted min-first priority queue built from a chain of slot cells.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one insert or remove per cycle unless in_stall holds it; every
// slot updates in parallel from its neighbors, and the output register frees
// when its result is taken. Reset (arst_n low) empties the queue and drops
// any pending result; entry data is not cleared.
`default_nettype none
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              operation,
	input  wire signed [spq_pkg::DATA_W-1:0] value,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [1:0]                       status,
	output logic signed [spq_pkg::DATA_W-1:0] removed_value,
	output logic [CNT_W-1:0]                 occupancy
);
	import spq_pkg::*;

	link_t                    links [QUEUE_DEPTH];
	link_t                    head_link;
	link_t                    tail_link;
	logic                     accept;
	logic                     is_remove;
	logic                     full;
	logic                     empty;
	logic                     ins_en;
	logic                     rem_en;
	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [CNT_W-1:0]         count_q;
	logic [QUEUE_DEPTH-1:0]   valid_vec;

	assign head_link = '{valid: 1'b1, le: 1'b1, data: '0};
	assign tail_link = '{valid: 1'b0, le: 1'b0, data: '0};

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign is_remove = (operation == OP_REMOVE);
	assign full      = links[QUEUE_DEPTH-1].valid;
	assign empty     = !links[0].valid;
	assign ins_en    = accept && !is_remove && !full;
	assign rem_en    = accept && is_remove && !empty;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign valid_vec[i] = links[i].valid;
		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins_en   (ins_en),
			.rem_en   (rem_en),
			.ins_val  (value),
			.prev_link((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
			.next_link((i == QUEUE_DEPTH - 1) ? tail_link
				: links[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.link     (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ins_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rem_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_remove) begin
				status_q  <= empty ? ST_EMPTY : ST_OK;
				removed_q <= empty ? '0 : links[0].data;
			end else begin
				status_q  <= full ? ST_FULL : ST_OK;
				removed_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign occupancy     = count_q;

`ifndef NO_ASSERTIONS
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == empty)
		else $error("count and head slot disagree on empty");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(QUEUE_DEPTH)) == full)
		else $error("count and tail slot disagree on full");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
		else $error("occupied slots not contiguous from head");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("count differs from occupied slots");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ST_OK || status_q == ST_FULL
			|| status_q == ST_EMPTY))
		else $error("illegal status in output register");
`endif

endmodule
`default_nettype wire

@@ design/spq_cell.sv @@
// One queue slot: holds an entry and shifts data in from its neighbors.
`default_nettype none
module spq_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            ins_en,
	input  wire                            rem_en,
	input  wire signed [spq_pkg::DATA_W-1:0] ins_val,
	input  wire spq_pkg::link_t            prev_link,
	input  wire spq_pkg::link_t            next_link,
	output spq_pkg::link_t                 link
);
	import spq_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     le;

	assign le = valid_q && (data_q <= ins_val);

	assign link.valid = valid_q;
	assign link.le    = le;
	assign link.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_en && !le) begin
			valid_q <= prev_link.valid;
		end else if (rem_en) begin
			valid_q <= next_link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en && !le) begin
			data_q <= prev_link.le ? ins_val : prev_link.data;
		end else if (rem_en) begin
			data_q <= next_link.data;
		end
	end

endmodule
`default_nettype wire
